// ----- sv/crtd_pkg.sv -----
// Shared types and constants for the x86 call/return target decoder.
// Used by every module of the block; depends on nothing.
package crtd_pkg;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   localparam logic [7:0] OPC_CALL_REL = 8'hE8;
   localparam logic [7:0] OPC_GRP5     = 8'hFF;
   localparam logic [7:0] OPC_RET      = 8'hC3;
   localparam logic [7:0] OPC_RET_IMM  = 8'hC2;

   localparam logic [2:0] REG_ESP = 3'd4;
   localparam logic [2:0] REG_EBP = 3'd5;

   localparam logic [1:0] MOD_NONE = 2'd0;
   localparam logic [1:0] MOD_D8   = 2'd1;
   localparam logic [1:0] MOD_D32  = 2'd2;
   localparam logic [1:0] MOD_REG  = 2'd3;

   localparam int NUM_REGS = 8;

   typedef struct packed {
      logic        mode;
      logic [2:0]  reg_index;
      logic [31:0] reg_value;
      logic [31:0] instr_pointer;
      logic [63:0] instr_bytes;
      logic        at_breakpoint;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] target;
      logic        target_in_memory;
      logic [2:0]  instr_size;
      logic        is_call;
      logic        is_ret;
   } rsp_type;

   // A decoded item. For a register load, base_sel is the register and disp
   // the value. For an evaluation the target is
   // (idx_en ? reg[idx_sel] << scale : 0) + (base_en ? reg[base_sel] : 0) + disp.
   typedef struct packed {
      logic        is_load;
      logic        ok;
      logic        in_mem;
      logic        is_call;
      logic        is_ret;
      logic [2:0]  size;
      logic        base_en;
      logic [2:0]  base_sel;
      logic        idx_en;
      logic [2:0]  idx_sel;
      logic [1:0]  scale;
      logic [31:0] disp;
   } dec_type;

endpackage

// ----- sv/crtd_front.sv -----
// Front end: accepts request items and decodes opcode, ModRM, SIB and displacement.
// Depends on crtd_pkg; feeds decoded items to crtd_queue.
module crtd_front import crtd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    q_full,
   output logic    q_push,
   output dec_type q_data
);

   logic    valid_ff, valid_in;
   dec_type data_ff, data_in;
   logic    accept;

   logic [63:0] b;
   logic [7:0]  op, modrm, sib;
   logic [1:0]  md;
   logic [2:0]  rm;
   logic [2:0]  pos;
   logic [2:0]  disp_size;
   logic [7:0]  d8;
   logic [31:0] d32;

   assign q_push    = valid_ff && !q_full;
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && q_full);
   assign q_data    = data_ff;

   assign b     = req_data.instr_bytes;
   assign op    = b[7:0];
   assign modrm = b[15:8];
   assign sib   = b[23:16];
   assign md    = modrm[7:6];
   assign rm    = modrm[2:0];
   assign d8    = (rm == REG_ESP) ? b[31:24] : b[23:16];
   assign d32   = (rm == REG_ESP) ? b[55:24] : b[47:16];

   always_comb begin
      data_in   = '0;
      pos       = 3'd2;
      disp_size = 3'd0;
      if (req_data.mode == MODE_LOAD) begin
         data_in.is_load  = 1'b1;
         data_in.base_sel = req_data.reg_index;
         data_in.disp     = req_data.reg_value;
      end else if (req_data.at_breakpoint) begin
         data_in.ok   = 1'b1;
         data_in.size = 3'd1;
         data_in.disp = req_data.instr_pointer + 32'd1;
      end else if (op == OPC_CALL_REL) begin
         data_in.ok      = 1'b1;
         data_in.is_call = 1'b1;
         data_in.size    = 3'd5;
         data_in.disp    = req_data.instr_pointer + 32'd5 + b[39:8];
      end else if (op == OPC_GRP5) begin
         data_in.ok      = 1'b1;
         data_in.is_call = 1'b1;
         if (md == MOD_REG) begin
            data_in.base_en  = 1'b1;
            data_in.base_sel = rm;
            data_in.size     = 3'd2;
         end else begin
            data_in.in_mem = 1'b1;
            case (md)
               MOD_D8:  disp_size = 3'd1;
               MOD_D32: disp_size = 3'd4;
               default: disp_size = 3'd0;
            endcase
            if (rm == REG_ESP) begin
               pos             = 3'd3;
               data_in.scale   = sib[7:6];
               data_in.idx_sel = sib[5:3];
               data_in.idx_en  = (sib[5:3] != REG_ESP);
               if (sib[2:0] == REG_EBP && md == MOD_NONE) begin
                  disp_size = 3'd4;
               end else begin
                  data_in.base_en  = 1'b1;
                  data_in.base_sel = sib[2:0];
               end
            end else if (rm == REG_EBP && md == MOD_NONE) begin
               disp_size = 3'd4;
            end else begin
               data_in.base_en  = 1'b1;
               data_in.base_sel = rm;
            end
            case (disp_size)
               3'd1:    data_in.disp = {{24{d8[7]}}, d8};
               3'd4:    data_in.disp = d32;
               default: data_in.disp = '0;
            endcase
            data_in.size = pos + disp_size;
         end
      end else if (op == OPC_RET || op == OPC_RET_IMM) begin
         data_in.ok       = 1'b1;
         data_in.is_ret   = 1'b1;
         data_in.in_mem   = 1'b1;
         data_in.base_en  = 1'b1;
         data_in.base_sel = REG_ESP;
         data_in.size     = (op == OPC_RET_IMM) ? 3'd3 : 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- sv/crtd_queue.sv -----
// Short first-in first-out queue of decoded items between front and back end.
// Depends on crtd_pkg for the item type.
module crtd_queue import crtd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  dec_type push_data,
   output logic    full,
   output logic    pop_valid,
   output dec_type pop_data,
   input  logic    pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/crtd_back.sv -----
// Back end: holds the register file, performs loads and forms the target address.
// Depends on crtd_pkg; takes decoded items from crtd_queue.
module crtd_back import crtd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  dec_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [31:0]         reg_file_ff [NUM_REGS];
   logic [NUM_REGS-1:0] reg_vld_ff;

   logic        exe_valid_ff;
   dec_type     exe_ctl_ff;
   logic [31:0] base_rd_ff;
   logic [31:0] idx_rd_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic rsp_load, exe_free, pop_eval, pop_load;

   assign rsp_load  = exe_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign exe_free  = !exe_valid_ff || rsp_load;
   assign q_pop     = q_valid && (q_data.is_load || exe_free);
   assign pop_eval  = q_pop && !q_data.is_load;
   assign pop_load  = q_pop && q_data.is_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register file; an entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (pop_load) begin
         reg_file_ff[q_data.base_sel] <= q_data.disp;
      end
      if (pop_eval) begin
         base_rd_ff <= (q_data.base_en && reg_vld_ff[q_data.base_sel]) ?
                       reg_file_ff[q_data.base_sel] : '0;
         idx_rd_ff  <= (q_data.idx_en && reg_vld_ff[q_data.idx_sel]) ?
                       reg_file_ff[q_data.idx_sel] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
      end else if (pop_load) begin
         reg_vld_ff[q_data.base_sel] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
      end else if (exe_free) begin
         exe_valid_ff <= pop_eval;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_eval) begin
         exe_ctl_ff <= q_data;
      end
   end

   always_comb begin
      rsp_data_in.ok               = exe_ctl_ff.ok;
      rsp_data_in.target           = (idx_rd_ff << exe_ctl_ff.scale) + base_rd_ff +
                                     exe_ctl_ff.disp;
      rsp_data_in.target_in_memory = exe_ctl_ff.in_mem;
      rsp_data_in.instr_size       = exe_ctl_ff.size;
      rsp_data_in.is_call          = exe_ctl_ff.is_call;
      rsp_data_in.is_ret           = exe_ctl_ff.is_ret;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- sv/x86_call_ret_target_decoder_core.sv -----
// Top level of the x86 call/return target decoder.
// Depends on crtd_pkg, crtd_front, crtd_queue and crtd_back.
//
//   Channel  Ports                        Direction  Carries
//   request  req_valid req_stall req_data in         register load or instruction
//   response rsp_valid rsp_stall rsp_data out        next-address result item
//
// One item is accepted per cycle while req_stall is low. An evaluation result passes
// through the decode register, queue, register file read and result register.
// Loads give no result and finish when they leave the queue.
// Synchronous reset empties the pipeline and makes every register read as zero.
// A stalled response fills the result and read stages, then the queue of
// QUEUE_DEPTH items (at least 2) and the decode register, after which req_stall is raised.
module x86_call_ret_target_decoder_core import crtd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    q_full, q_push, q_valid, q_pop;
   dec_type q_wr_data, q_rd_data;

   crtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   crtd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (q_rd_data),
      .pop       (q_pop)
   );

   crtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/next_address_checker.sv -----
// Checker for the x86 call/return target decoder: watches both channels, predicts each
// result item from its own copy of the register file and compares it field by field.
// Depends on crtd_pkg.
module next_address_checker import crtd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] gpr_copy [NUM_REGS];
   rsp_type     pending_targets [$];

   function automatic rsp_type next_address(req_type item);
      rsp_type     res;
      logic [63:0] b;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic [7:0]  sib;
      logic [31:0] ea;
      int          pos;
      int          disp_len;
      res = '0;
      b = item.instr_bytes;
      opcode = b[7:0];
      modrm = b[15:8];
      if (item.at_breakpoint) begin
         res.ok = 1'b1;
         res.target = item.instr_pointer + 32'd1;
         res.instr_size = 3'd1;
      end else if (opcode == OPC_CALL_REL) begin
         res.ok = 1'b1;
         res.target = item.instr_pointer + 32'd5 + b[39:8];
         res.instr_size = 3'd5;
         res.is_call = 1'b1;
      end else if (opcode == OPC_GRP5) begin
         res.ok = 1'b1;
         res.is_call = 1'b1;
         if (modrm[7:6] == MOD_REG) begin
            res.target = gpr_copy[modrm[2:0]];
            res.instr_size = 3'd2;
         end else begin
            pos = 2;
            ea = '0;
            disp_len = (modrm[7:6] == MOD_D8) ? 1 : (modrm[7:6] == MOD_D32) ? 4 : 0;
            if (modrm[2:0] == REG_ESP) begin
               sib = b[23:16];
               pos = 3;
               if (sib[5:3] != REG_ESP) ea = gpr_copy[sib[5:3]] << sib[7:6];
               if (sib[2:0] == REG_EBP && modrm[7:6] == MOD_NONE) disp_len = 4;
               else ea = ea + gpr_copy[sib[2:0]];
            end else if (modrm[2:0] == REG_EBP && modrm[7:6] == MOD_NONE) begin
               disp_len = 4;
            end else begin
               ea = gpr_copy[modrm[2:0]];
            end
            if (disp_len == 1) ea = ea + {{24{b[8*pos+7]}}, b[8*pos +: 8]};
            else if (disp_len == 4) ea = ea + b[8*pos +: 32];
            res.target = ea;
            res.target_in_memory = 1'b1;
            res.instr_size = 3'(pos + disp_len);
         end
      end else if (opcode == OPC_RET || opcode == OPC_RET_IMM) begin
         res.ok = 1'b1;
         res.target = gpr_copy[REG_ESP];
         res.target_in_memory = 1'b1;
         res.instr_size = (opcode == OPC_RET_IMM) ? 3'd3 : 3'd1;
         res.is_ret = 1'b1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (gpr_copy[i]) gpr_copy[i] = '0;
         pending_targets.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.mode == MODE_LOAD) gpr_copy[req_data.reg_index] = req_data.reg_value;
            else pending_targets.push_back(next_address(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_targets.size() == 0) begin
               $error("result item with none expected: target %0h", rsp_data.target);
               error_count++;
            end else begin
               want = pending_targets.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_data.ok));
               check_field("target", want.target, rsp_data.target);
               check_field("target_in_memory", 32'(want.target_in_memory),
                           32'(rsp_data.target_in_memory));
               check_field("instr_size", 32'(want.instr_size), 32'(rsp_data.instr_size));
               check_field("is_call", 32'(want.is_call), 32'(rsp_data.is_call));
               check_field("is_ret", 32'(want.is_ret), 32'(rsp_data.is_ret));
            end
         end
      end
      pending_count = pending_targets.size();
   end

endmodule

// ----- verif/x86_call_ret_target_decoder_core_test.sv -----
// Top of the testbench for x86_call_ret_target_decoder_core: clock, reset, directed and
// random stimulus, response stalls, watchdog and the verdict.
// Depends on crtd_pkg, the block and next_address_checker.
module x86_call_ret_target_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import crtd_pkg::*;

   localparam logic [2:0] REG_EAX   = 3'd0;
   localparam logic [2:0] REG_ECX   = 3'd1;
   localparam logic [2:0] REG_EBX   = 3'd3;
   localparam logic [2:0] REG_ESI   = 3'd6;
   localparam logic [2:0] REG_EDI   = 3'd7;
   localparam logic [2:0] GRP5_CALL = 3'd2;
   localparam logic [7:0] OPC_NOP   = 8'h90;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 8;
   localparam int NUM_PHASES     = 5;
   localparam int PHASE_ITEMS    = 380;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCKS} stall_pattern_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   req_type           req_data  = '0;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   rsp_type           rsp_data;
   int                error_count;
   int                pending_count;
   int                burst_left  = 0;
   bit                steady_send = 1'b0;
   stall_pattern_type stall_mode  = STALL_NONE;
   int                stall_left  = 0;
   int                idle_cycles = 0;

   x86_call_ret_target_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   next_address_checker monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_pattern_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_left % 16) < 10);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] modrm_byte(logic [1:0] md, logic [2:0] op, logic [2:0] rm);
      return {md, op, rm};
   endfunction

   function automatic logic [7:0] sib_byte(logic [1:0] scale, logic [2:0] idx,
                                           logic [2:0] base);
      return {scale, idx, base};
   endfunction

   function automatic req_type load_item(logic [2:0] idx, logic [31:0] value);
      req_type r;
      r.mode = MODE_LOAD;
      r.reg_index = idx;
      r.reg_value = value;
      r.instr_pointer = $urandom;
      r.instr_bytes = {$urandom, $urandom};
      r.at_breakpoint = 1'($urandom);
      return r;
   endfunction

   function automatic req_type eval_item(logic [31:0] ip, logic [63:0] bytes, logic bkpt);
      req_type r;
      r.mode = MODE_EVAL;
      r.reg_index = 3'($urandom);
      r.reg_value = $urandom;
      r.instr_pointer = ip;
      r.instr_bytes = bytes;
      r.at_breakpoint = bkpt;
      return r;
   endfunction

   function automatic req_type random_eval();
      logic [63:0] b;
      int          kind;
      logic        bkpt;
      b = {$urandom, $urandom};
      bkpt = 1'b0;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         bkpt = 1'b1;
      end else if (kind < 28) begin
         b[7:0] = OPC_CALL_REL;
      end else if (kind < 68) begin
         b[7:0] = OPC_GRP5;
         if ($urandom_range(0, 3) == 0) b[15:14] = MOD_NONE;
         if ($urandom_range(0, 2) == 0) b[10:8] = REG_ESP;
         if ($urandom_range(0, 3) == 0) b[18:16] = REG_EBP;
      end else if (kind < 80) begin
         b[7:0] = OPC_RET;
      end else if (kind < 90) begin
         b[7:0] = OPC_RET_IMM;
      end
      return eval_item(random_word(), b, bkpt);
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = steady_send ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_item(eval_item(32'h0000_1000, {56'h0, OPC_RET}, 1'b0));
      for (int i = 0; i < NUM_REGS; i++) begin
         send_item(load_item(3'(i), (i == 0) ? 32'hFFFF_FFFF :
                                    (i == 1) ? 32'h8000_0000 : 32'h1111_1111 * i));
      end
      send_item(eval_item(32'hFFFF_FFFF, {56'h0, OPC_CALL_REL}, 1'b1));
      send_item(eval_item(32'hFFFF_FFFF, {24'h0, 32'hFFFF_FFFF, OPC_CALL_REL}, 1'b0));
      send_item(eval_item(32'h0000_0000, {24'hFF_FFFF, 32'h7FFF_FFFF, OPC_CALL_REL}, 1'b0));
      send_item(eval_item(32'h0040_0000,
                          {48'h0, modrm_byte(MOD_REG, GRP5_CALL, REG_EDI), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0010, {16'h0, 32'h1234_5678,
                          modrm_byte(MOD_NONE, GRP5_CALL, REG_EBP), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0020, {8'h0, 32'hDEAD_BEEF,
                          sib_byte(2'd3, REG_ESP, REG_EBP),
                          modrm_byte(MOD_NONE, GRP5_CALL, REG_ESP), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0030, {32'h0, 8'h80, sib_byte(2'd3, REG_ECX, REG_ESP),
                          modrm_byte(MOD_D8, GRP5_CALL, REG_ESP), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0040, {40'h0, sib_byte(2'd2, REG_EAX, REG_EBX),
                          modrm_byte(MOD_NONE, GRP5_CALL, REG_ESP), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0050, {16'h0, 32'hFFFF_FFFF,
                          modrm_byte(MOD_D32, GRP5_CALL, REG_EAX), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0060, {40'h0, 8'h7F,
                          modrm_byte(MOD_D8, GRP5_CALL, REG_EBP), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0070, {8'h0, 32'h8000_0000,
                          sib_byte(2'd1, REG_EDI, REG_ESI),
                          modrm_byte(MOD_D32, GRP5_CALL, REG_ESP), OPC_GRP5}, 1'b0));
      send_item(eval_item(32'h0040_0080, {40'h0, 16'h0010, OPC_RET_IMM}, 1'b0));
      send_item(eval_item(32'h0040_0090, {56'hFF_FFFF_FFFF_FFFF, OPC_NOP}, 1'b0));
      send_item(eval_item(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      send_item(eval_item(32'h0000_0000, 64'h0, 1'b0));
      send_item(load_item(REG_ESP, 32'hFFFF_FFFC));
      send_item(eval_item(32'h0040_00A0, {56'h0, OPC_RET}, 1'b0));
      pause_until_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         steady_send = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 3) send_item(load_item(3'($urandom), random_word()));
            else send_item(random_eval());
         end
         pause_until_drained();
      end

      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
